// File: sv/ppcd_pkg.sv
package ppcd_pkg;

	// Coordinate format: signed Q16.8.
	localparam int COORD_W = 24;
	localparam int FRAC_W  = 8;

	// A coordinate difference needs one more bit than a coordinate.
	localparam int DIFF_W = COORD_W + 1;
	// Multiplier operands hold a signed difference or an unsigned 25-bit root.
	localparam int OPND_W = COORD_W + 2;
	localparam int PROD_W = 2 * OPND_W;
	// Sums of two products (cross, squared lengths, dot products).
	localparam int ACC_W  = 2 * COORD_W + 3;
	// Distance and root width; the all-ones value is the saturation limit.
	localparam int DIST_W = COORD_W + 1;
	localparam int BIT_W  = $clog2(DIST_W);

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Multiply steps of one edge: two products for each of six sums.
	localparam int NSTEP  = 12;
	localparam int STEP_W = $clog2(NSTEP);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [DIST_W-1:0]         dist_t;

endpackage

// File: sv/polygon_point_containment_distance_core.sv
// Channel | Direction | Handshake            | Payload
// in      | receive   | in_valid / in_stall   | point_x, point_z, vertex_x, vertex_z, last_vertex
// out     | send      | out_valid / out_stall | inside_res, edge_distance
//
// A first vertex that is not the last is only stored. Every edge runs on one shared
// 26x26 multiplier: 12 products, then, unless a squared length is zero, a bit-by-bit
// square root of 25 steps, and for the cross-over-length case a 25-step divide.
// A last vertex that is not also the first runs both its own edge and the closing edge.
// Reset clears the sequencer, the sign state, the minimum and the output valid.
// in_stall is high while an item is being worked; a waiting result only blocks the
// end of the next polygon.
module polygon_point_containment_distance_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [ppcd_pkg::COORD_W-1:0] point_x,
	input  logic signed [ppcd_pkg::COORD_W-1:0] point_z,
	input  logic signed [ppcd_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [ppcd_pkg::COORD_W-1:0] vertex_z,
	input  logic                           last_vertex,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           inside_res,
	output logic [ppcd_pkg::DIST_W-1:0]    edge_distance
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_ITER   = 3'd4;
	localparam logic [2:0] ST_UPDATE = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	localparam logic [1:0] SGN_NONE = 2'd0;
	localparam logic [1:0] SGN_POS  = 2'd1;
	localparam logic [1:0] SGN_NEG  = 2'd2;

	logic [2:0] state_q;
	logic       expect_first_q;
	logic       close_pend_q;
	logic       last_q;
	logic [1:0] sign_q;
	logic       outside_q;
	ppcd_pkg::dist_t  best_q;
	ppcd_pkg::coord_t first_x_q, first_z_q, prev_x_q, prev_z_q, px_q, pz_q;
	ppcd_pkg::coord_t sx_q, sz_q, ex_q, ez_q;
	ppcd_pkg::diff_t  esx_q, esz_q, psx_q, psz_q, pex_q, pez_q;
	ppcd_pkg::acc_t   acc_q, cr_q, a2_q, b2_q, c2_q, ds_q, de_q, n_q;
	logic signed [ppcd_pkg::PROD_W-1:0] prod_q;
	logic [ppcd_pkg::STEP_W-1:0] step_q;
	logic       ph_q;
	logic [ppcd_pkg::BIT_W-1:0] kcnt_q;
	ppcd_pkg::dist_t res_q, dvs_q, dist_q;
	logic       div_mode_q, need_div_q;
	logic       out_valid_q, inside_q;
	ppcd_pkg::dist_t out_dist_q;

	logic signed [ppcd_pkg::OPND_W-1:0] opa, opb;
	ppcd_pkg::dist_t tval, res_nx;
	ppcd_pkg::acc_t  prod_acc, abs_cr;
	logic            take;
	logic            in_xfer;

	assign in_stall      = (state_q != ST_IDLE);
	assign in_xfer       = in_valid && !in_stall;
	assign out_valid     = out_valid_q;
	assign inside_res    = inside_q;
	assign edge_distance = out_dist_q;

	// Trial value of the root or quotient for the current bit.
	assign tval     = res_q | (ppcd_pkg::dist_t'(1) << kcnt_q);
	assign prod_acc = prod_q[ppcd_pkg::ACC_W-1:0];
	assign take     = (prod_acc <= n_q);
	assign res_nx   = take ? tval : res_q;
	assign abs_cr   = cr_q[ppcd_pkg::ACC_W-1] ? -cr_q : cr_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		opa = '0;
		opb = '0;
		if (state_q == ST_ITER) begin
			opa = $signed({1'b0, tval});
			opb = div_mode_q ? $signed({1'b0, dvs_q}) : $signed({1'b0, tval});
		end else begin
			case (step_q)
				4'd0: begin opa = {esz_q[ppcd_pkg::DIFF_W-1], esz_q}; opb = {psx_q[ppcd_pkg::DIFF_W-1], psx_q}; end
				4'd1: begin opa = {esx_q[ppcd_pkg::DIFF_W-1], esx_q}; opb = {psz_q[ppcd_pkg::DIFF_W-1], psz_q}; end
				4'd2: begin opa = {pex_q[ppcd_pkg::DIFF_W-1], pex_q}; opb = {pex_q[ppcd_pkg::DIFF_W-1], pex_q}; end
				4'd3: begin opa = {pez_q[ppcd_pkg::DIFF_W-1], pez_q}; opb = {pez_q[ppcd_pkg::DIFF_W-1], pez_q}; end
				4'd4: begin opa = {psx_q[ppcd_pkg::DIFF_W-1], psx_q}; opb = {psx_q[ppcd_pkg::DIFF_W-1], psx_q}; end
				4'd5: begin opa = {psz_q[ppcd_pkg::DIFF_W-1], psz_q}; opb = {psz_q[ppcd_pkg::DIFF_W-1], psz_q}; end
				4'd6: begin opa = {esx_q[ppcd_pkg::DIFF_W-1], esx_q}; opb = {esx_q[ppcd_pkg::DIFF_W-1], esx_q}; end
				4'd7: begin opa = {esz_q[ppcd_pkg::DIFF_W-1], esz_q}; opb = {esz_q[ppcd_pkg::DIFF_W-1], esz_q}; end
				4'd8: begin opa = {psx_q[ppcd_pkg::DIFF_W-1], psx_q}; opb = {esx_q[ppcd_pkg::DIFF_W-1], esx_q}; end
				4'd9: begin opa = {psz_q[ppcd_pkg::DIFF_W-1], psz_q}; opb = {esz_q[ppcd_pkg::DIFF_W-1], esz_q}; end
				4'd10: begin opa = {pex_q[ppcd_pkg::DIFF_W-1], pex_q}; opb = {esx_q[ppcd_pkg::DIFF_W-1], esx_q}; end
				4'd11: begin opa = {pez_q[ppcd_pkg::DIFF_W-1], pez_q}; opb = {esz_q[ppcd_pkg::DIFF_W-1], esz_q}; end
				default: begin opa = '0; opb = '0; end
			endcase
		end
	end

	// Registered product of the shared multiplier.
	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (expect_first_q) begin
						sx_q <= vertex_x;
						sz_q <= vertex_z;
					end else begin
						sx_q <= prev_x_q;
						sz_q <= prev_z_q;
					end
					ex_q <= vertex_x;
					ez_q <= vertex_z;
				end
			end
			ST_SETUP: begin
				esx_q <= ppcd_pkg::DIFF_W'(ex_q) - ppcd_pkg::DIFF_W'(sx_q);
				esz_q <= ppcd_pkg::DIFF_W'(ez_q) - ppcd_pkg::DIFF_W'(sz_q);
				psx_q <= ppcd_pkg::DIFF_W'(px_q) - ppcd_pkg::DIFF_W'(sx_q);
				psz_q <= ppcd_pkg::DIFF_W'(pz_q) - ppcd_pkg::DIFF_W'(sz_q);
				pex_q <= ppcd_pkg::DIFF_W'(px_q) - ppcd_pkg::DIFF_W'(ex_q);
				pez_q <= ppcd_pkg::DIFF_W'(pz_q) - ppcd_pkg::DIFF_W'(ez_q);
			end
			ST_MUL: begin
				// Even steps load the accumulator, odd steps finish a sum.
				if (ph_q) begin
					if (!step_q[0]) begin
						acc_q <= prod_acc;
					end else begin
						case (step_q)
							4'd1: cr_q <= acc_q - prod_acc;
							4'd3: a2_q <= acc_q + prod_acc;
							4'd5: b2_q <= acc_q + prod_acc;
							4'd7: c2_q <= acc_q + prod_acc;
							4'd9: ds_q <= acc_q + prod_acc;
							default: de_q <= acc_q + prod_acc;
						endcase
					end
				end
			end
			ST_DECIDE: begin
				res_q      <= '0;
				div_mode_q <= 1'b0;
				need_div_q <= 1'b0;
				dist_q     <= '0;
				// A zero dot product at the start or the end counts as obtuse.
				if (a2_q == '0 || b2_q == '0 || c2_q == '0) begin
					dist_q <= '0;
				end else if (ds_q[ppcd_pkg::ACC_W-1] || ds_q == '0) begin
					n_q <= b2_q;
				end else if (!de_q[ppcd_pkg::ACC_W-1]) begin
					n_q <= a2_q;
				end else begin
					n_q        <= c2_q;
					need_div_q <= 1'b1;
				end
			end
			ST_ITER: begin
				if (ph_q) begin
					res_q <= res_nx;
					if (kcnt_q == '0) begin
						if (need_div_q) begin
							need_div_q <= 1'b0;
							if ({{(ppcd_pkg::ACC_W-2*ppcd_pkg::DIST_W){1'b0}}, res_nx,
								{ppcd_pkg::DIST_W{1'b0}}} <= abs_cr) begin
								dist_q <= ppcd_pkg::DIST_MAX;
							end else begin
								dvs_q      <= res_nx;
								n_q        <= abs_cr;
								res_q      <= '0;
								div_mode_q <= 1'b1;
							end
						end else begin
							dist_q <= res_nx;
						end
					end
				end
			end
			ST_UPDATE: begin
				if (close_pend_q) begin
					sx_q <= ex_q;
					sz_q <= ez_q;
					ex_q <= first_x_q;
					ez_q <= first_z_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			expect_first_q <= 1'b1;
			close_pend_q   <= 1'b0;
			last_q         <= 1'b0;
			sign_q         <= SGN_NONE;
			outside_q      <= 1'b0;
			best_q         <= ppcd_pkg::DIST_MAX;
			first_x_q      <= '0;
			first_z_q      <= '0;
			prev_x_q       <= '0;
			prev_z_q       <= '0;
			px_q           <= '0;
			pz_q           <= '0;
			step_q         <= '0;
			ph_q           <= 1'b0;
			kcnt_q         <= '0;
			out_valid_q    <= 1'b0;
			inside_q       <= 1'b0;
			out_dist_q     <= '0;
		end else begin
			// In the output state a taken result is replaced by the new one below.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						prev_x_q <= vertex_x;
						prev_z_q <= vertex_z;
						last_q   <= last_vertex;
						if (expect_first_q) begin
							px_q           <= point_x;
							pz_q           <= point_z;
							first_x_q      <= vertex_x;
							first_z_q      <= vertex_z;
							expect_first_q <= 1'b0;
							close_pend_q   <= 1'b0;
							// A lone vertex runs only its closing edge.
							if (last_vertex) begin
								state_q <= ST_SETUP;
							end
						end else begin
							close_pend_q <= last_vertex;
							state_q      <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					step_q  <= '0;
					ph_q    <= 1'b0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q == ppcd_pkg::STEP_W'(ppcd_pkg::NSTEP - 1)) begin
							state_q <= ST_DECIDE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					// The first nonzero cross sets the sign; a later opposite one marks outside.
					if (cr_q != '0) begin
						if (sign_q == SGN_NONE) begin
							sign_q <= cr_q[ppcd_pkg::ACC_W-1] ? SGN_NEG : SGN_POS;
						end else if (sign_q != (cr_q[ppcd_pkg::ACC_W-1] ? SGN_NEG : SGN_POS)) begin
							outside_q <= 1'b1;
						end
					end
					ph_q   <= 1'b0;
					kcnt_q <= ppcd_pkg::BIT_W'(ppcd_pkg::DIST_W - 1);
					if (a2_q == '0 || b2_q == '0 || c2_q == '0) begin
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (kcnt_q == '0) begin
							kcnt_q <= ppcd_pkg::BIT_W'(ppcd_pkg::DIST_W - 1);
							if (!need_div_q || ({{(ppcd_pkg::ACC_W-2*ppcd_pkg::DIST_W){1'b0}},
								res_nx, {ppcd_pkg::DIST_W{1'b0}}} <= abs_cr)) begin
								state_q <= ST_UPDATE;
							end
						end else begin
							kcnt_q <= kcnt_q - 1'b1;
						end
					end
				end
				ST_UPDATE: begin
					if (dist_q < best_q) begin
						best_q <= dist_q;
					end
					if (close_pend_q) begin
						close_pend_q <= 1'b0;
						state_q      <= ST_SETUP;
					end else if (last_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					// Load the result once the output register is free, then rearm.
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						inside_q       <= !outside_q;
						out_dist_q     <= best_q;
						sign_q         <= SGN_NONE;
						outside_q      <= 1'b0;
						best_q         <= ppcd_pkg::DIST_MAX;
						expect_first_q <= 1'b1;
						last_q         <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
